// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the rotation matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/rmbv_pkg.sv -----
// Shared constants and types of the rotation matrix block.
package rmbv_pkg;

  localparam int IN_W = 16;
  localparam int OUT_W = 16;
  localparam int SQRT_LAT = 32;
  localparam int DIV_LAT = 32;
  // Normalize unit: shift, square, sum, root, divide, sign.
  localparam int LAT_UNIT = 3 + SQRT_LAT + DIV_LAT + 1;
  // Matrix part: four stages ahead of the root, six after the divide.
  localparam int LAT_TOTAL = LAT_UNIT + 4 + SQRT_LAT + DIV_LAT + 6;

  typedef logic signed [IN_W-1:0] in_t;
  typedef logic signed [31:0] q30_t;
  typedef logic signed [OUT_W-1:0] out_t;

endpackage

// ----- rtl/core/rotation_matrix_between_vectors.sv -----
// Top level: rotation matrix that turns one 3-D direction onto another.
//
//   channel | beat content                         | handshake
//   --------+--------------------------------------+----------------------
//   in      | from_x..from_z, to_x..to_z           | in_valid / in_ready
//   out     | m00..m22 (Q1.14), degenerate         | out_valid / out_ready
//
// One beat enters per cycle while the output buffer has room; most of the
// length comes from the two root-and-divide chains, 32 stages per root and per divide.
// A two-entry output buffer holds finished results; the whole pipeline
// advances as one and stops only while that buffer is full.
// Reset clears the valid bits and the buffer count; the data path has no reset.
module rotation_matrix_between_vectors import rmbv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  from_x,
  input  in_t  from_y,
  input  in_t  from_z,
  input  in_t  to_x,
  input  in_t  to_y,
  input  in_t  to_z,
  output logic out_valid,
  input  logic out_ready,
  output out_t m00,
  output out_t m01,
  output out_t m02,
  output out_t m10,
  output out_t m11,
  output out_t m12,
  output out_t m20,
  output out_t m21,
  output out_t m22,
  output logic degenerate
);

  localparam logic signed [63:0] QONE = 64'sd1 << 30;
  localparam int KMAG_AT = SQRT_LAT;
  localparam int SIDE_LEN = SQRT_LAT + DIV_LAT;

  typedef struct packed {
    logic [8:0][OUT_W-1:0] m;
    logic                  dg;
  } res_t;

  typedef struct packed {
    logic [2:0][31:0] kmag;
    logic [2:0]       kneg;
    logic [31:0]      c;
    logic             dg;
  } side_t;

  // Round half away from zero after dropping 30 fraction bits.
  function automatic logic signed [63:0] rsh30(logic signed [63:0] x);
    logic signed [63:0] r;
    if (x >= 0) begin
      r = (x + 64'sd536870912) >>> 30;
    end else begin
      r = -((-x + 64'sd536870912) >>> 30);
    end
    return r;
  endfunction

  // Round to Q1.14 and saturate to plus or minus one.
  function automatic logic [OUT_W-1:0] to_out(logic signed [34:0] e);
    logic signed [34:0] t;
    if (e >= 0) begin
      t = (e + 35'sd32768) >>> 16;
    end else begin
      t = -((-e + 35'sd32768) >>> 16);
    end
    if (t > 35'sd16384) begin
      t = 35'sd16384;
    end else if (t < -35'sd16384) begin
      t = -35'sd16384;
    end
    return t[OUT_W-1:0];
  endfunction

  logic                 en;
  logic [1:0]           cnt;
  logic [1:0]           cnt_next;
  logic [LAT_TOTAL-1:0] vld;
  logic                 push;
  logic                 pop;
  res_t                 res;
  res_t                 ob0;
  res_t                 ob1;

  q30_t uf [3];
  q30_t vt [3];
  logic zf;
  logic zt;

  logic signed [63:0] cra [3];
  logic signed [63:0] crb [3];
  logic signed [63:0] dt [3];
  logic               dg1;

  logic signed [63:0] kr [3];
  logic signed [63:0] cr;
  q30_t               k2 [3];
  q30_t               c2;
  logic               dg2;

  logic [63:0]        kk3 [3];
  q30_t               k3 [3];
  q30_t               c3;
  logic               dg3;

  logic [63:0]        kk4;
  side_t              side4;

  side_t              side [SIDE_LEN];
  logic [31:0]        s;
  logic [31:0]        sd [DIV_LAT];
  logic [63:0]        anum [3];
  logic [31:0]        aquo [3];

  q30_t               ax5 [3];
  logic [31:0]        s5;
  q30_t               c5;
  logic signed [32:0] omc5;
  logic               dg5;

  logic signed [64:0] as_w [3];
  logic signed [63:0] as6 [3];
  logic signed [63:0] aa6 [6];
  q30_t               c6;
  logic signed [32:0] omc6;
  logic               dg6;

  q30_t               r7 [3];
  q30_t               t7 [6];
  q30_t               c7;
  logic signed [32:0] omc7;
  logic               dg7;

  logic signed [64:0] p_w [6];
  logic signed [63:0] p8 [6];
  q30_t               r8 [3];
  q30_t               c8;
  logic               dg8;

  logic signed [34:0] e9 [9];
  logic               dg9;
  logic signed [34:0] pr [6];

  logic [8:0][OUT_W-1:0] o10;
  logic                  dg10;

  // Pipeline enable and the valid bits that travel with the data.
  assign en = (cnt != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT_TOTAL-2:0], in_valid};
    end
  end

  rmbv_unit u_from (
    .clk  (clk),
    .en   (en),
    .vx   (from_x),
    .vy   (from_y),
    .vz   (from_z),
    .u    (uf),
    .zero (zf)
  );

  rmbv_unit u_to (
    .clk  (clk),
    .en   (en),
    .vx   (to_x),
    .vy   (to_y),
    .vz   (to_z),
    .u    (vt),
    .zero (zt)
  );

  // Cross and dot product terms.
  always_ff @(posedge clk) begin
    if (en) begin
      cra[0] <= uf[1] * vt[2];
      crb[0] <= uf[2] * vt[1];
      cra[1] <= uf[2] * vt[0];
      crb[1] <= uf[0] * vt[2];
      cra[2] <= uf[0] * vt[1];
      crb[2] <= uf[1] * vt[0];
      for (int i = 0; i < 3; i++) begin
        dt[i] <= uf[i] * vt[i];
      end
      dg1 <= zf | zt;
    end
  end

  // Axis before normalizing, cosine clamped to the unit range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kr[i] = rsh30(cra[i] - crb[i]);
    end
    cr = rsh30(dt[0] + dt[1] + dt[2]);
    if (cr > QONE) begin
      cr = QONE;
    end else if (cr < -QONE) begin
      cr = -QONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        k2[i] <= kr[i][31:0];
      end
      c2 <= cr[31:0];
      dg2 <= dg1 | ((kr[0] == 64'sd0) && (kr[1] == 64'sd0) && (kr[2] == 64'sd0));
    end
  end

  // Squared axis length.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        kk3[i] <= k2[i] * k2[i];
        k3[i] <= k2[i];
      end
      c3 <= c2;
      dg3 <= dg2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kk4 <= kk3[0] + kk3[1] + kk3[2];
      for (int i = 0; i < 3; i++) begin
        side4.kmag[i] <= k3[i][31] ? 32'(-k3[i]) : 32'(k3[i]);
        side4.kneg[i] <= k3[i][31];
      end
      side4.c <= c3;
      side4.dg <= dg3;
    end
  end

  rmbv_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (kk4),
    .root (s)
  );

  // Side data across the root and the divide; the sine across the divide.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side4;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side[k] <= side[k-1];
      end
      sd[0] <= s;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // Unit axis: each component over the sine.
  for (genvar i = 0; i < 3; i++) begin : g_div
    assign anum[i] = {2'b00, side[KMAG_AT-1].kmag[i], 30'd0} + {33'd0, s[31:1]};

    rmbv_div u_div (
      .clk (clk),
      .en  (en),
      .num (anum[i]),
      .den (s),
      .quo (aquo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ax5[i] <= side[SIDE_LEN-1].kneg[i] ? -$signed(aquo[i]) : $signed(aquo[i]);
      end
      s5 <= sd[DIV_LAT-1];
      c5 <= side[SIDE_LEN-1].c;
      omc5 <= 33'sd1073741824 - 33'($signed(side[SIDE_LEN-1].c));
      dg5 <= side[SIDE_LEN-1].dg;
    end
  end

  // Axis times sine, and the outer product of the axis.
  always_comb begin
    for (int m = 0; m < 3; m++) begin
      as_w[m] = ax5[m] * $signed({1'b0, s5});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 3; m++) begin
        as6[m] <= as_w[m][63:0];
        aa6[m] <= ax5[m] * ax5[m];
      end
      aa6[3] <= ax5[0] * ax5[1];
      aa6[4] <= ax5[0] * ax5[2];
      aa6[5] <= ax5[1] * ax5[2];
      c6 <= c5;
      omc6 <= omc5;
      dg6 <= dg5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 3; m++) begin
        r7[m] <= 32'(rsh30(as6[m]));
      end
      for (int j = 0; j < 6; j++) begin
        t7[j] <= 32'(rsh30(aa6[j]));
      end
      c7 <= c6;
      omc7 <= omc6;
      dg7 <= dg6;
    end
  end

  // Outer product scaled by one minus the cosine.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      p_w[j] = t7[j] * omc7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        p8[j] <= p_w[j][63:0];
      end
      r8 <= r7;
      c8 <= c7;
      dg8 <= dg7;
    end
  end

  // Two terms per entry: the cosine on the diagonal, the skew part with the sine off it.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      pr[j] = 35'(rsh30(p8[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e9[0] <= 35'(c8) + pr[0];
      e9[4] <= 35'(c8) + pr[1];
      e9[8] <= 35'(c8) + pr[2];
      e9[1] <= pr[3] - 35'(r8[2]);
      e9[3] <= pr[3] + 35'(r8[2]);
      e9[2] <= pr[4] + 35'(r8[1]);
      e9[6] <= pr[4] - 35'(r8[1]);
      e9[5] <= pr[5] - 35'(r8[0]);
      e9[7] <= pr[5] + 35'(r8[0]);
      dg9 <= dg8;
    end
  end

  // Output format; a degenerate pair gives the identity.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        if (dg9) begin
          o10[i] <= (i % 4 == 0) ? 16'd16384 : 16'd0;
        end else begin
          o10[i] <= to_out(e9[i]);
        end
      end
      dg10 <= dg9;
    end
  end

  assign res = '{m: o10, dg: dg10};

  // Two-entry output buffer; ob0 drives the result ports.
  assign push = en && vld[LAT_TOTAL-1];
  assign pop = out_valid && out_ready;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          ob0 <= res;
        end else begin
          ob1 <= res;
        end
      end
      2'b01: begin
        ob0 <= ob1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          ob0 <= res;
        end else begin
          ob0 <= ob1;
          ob1 <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = (cnt != 2'd0);
  assign m00 = ob0.m[0];
  assign m01 = ob0.m[1];
  assign m02 = ob0.m[2];
  assign m10 = ob0.m[3];
  assign m11 = ob0.m[4];
  assign m12 = ob0.m[5];
  assign m20 = ob0.m[6];
  assign m21 = ob0.m[7];
  assign m22 = ob0.m[8];
  assign degenerate = ob0.dg;

  `include "assert_macros.svh"

  `ASSERT_IMPLY(a_degen_identity, clk, rst, out_valid && degenerate, m00 == 16'sd16384 && m11 == 16'sd16384 && m22 == 16'sd16384 && m01 == 16'sd0 && m12 == 16'sd0 && m20 == 16'sd0, "degenerate result is not the identity")
  `ASSERT_IMPLY(a_sat_range, clk, rst, out_valid, m00 <= 16'sd16384 && m00 >= -16'sd16384 && m12 <= 16'sd16384 && m12 >= -16'sd16384, "matrix entry outside plus or minus one")
  `ASSERT_NEXT(a_fill_step, clk, rst, cnt == 2'd0, cnt != 2'd2, "output buffer gained two beats in one cycle")

endmodule

// ----- rtl/core/rmbv_sqrt.sv -----
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module rmbv_sqrt import rmbv_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] r;
  } sqrt_st_t;

  // One step of the digit-by-digit root: try the next bit, keep it if it fits.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int k);
    logic [63:0] bitv;
    logic [64:0] sum;
    sqrt_st_t o;
    bitv = 64'd1 << (62 - 2 * k);
    sum = {1'b0, s.r} + {1'b0, bitv};
    if ({1'b0, s.rem} >= sum) begin
      o.rem = s.rem - sum[63:0];
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.rem = s.rem;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  sqrt_st_t st_in;
  sqrt_st_t st [SQRT_LAT];

  assign st_in = '{rem: x, r: 64'd0};

  // Stage registers advance together under the pipeline enable.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sqrt_step(st_in, 0);
      for (int k = 1; k < SQRT_LAT; k++) begin
        st[k] <= sqrt_step(st[k-1], k);
      end
    end
  end

  assign root = st[SQRT_LAT-1].r[31:0];

endmodule

// ----- rtl/core/rmbv_div.sv -----
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per stage.
module rmbv_div import rmbv_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] q;
    logic [31:0] den;
  } div_st_t;

  // Settle quotient bit 31-k by a trial subtract of the shifted divisor.
  function automatic div_st_t div_step(div_st_t d, int k);
    logic [63:0] sh;
    div_st_t o;
    o = d;
    sh = {32'd0, d.den} << (31 - k);
    if (d.rem >= sh) begin
      o.rem = d.rem - sh;
      o.q[31-k] = 1'b1;
    end
    return o;
  endfunction

  div_st_t st_in;
  div_st_t st [DIV_LAT];

  assign st_in = '{rem: num, q: 32'd0, den: den};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(st_in, 0);
      for (int k = 1; k < DIV_LAT; k++) begin
        st[k] <= div_step(st[k-1], k);
      end
    end
  end

  assign quo = st[DIV_LAT-1].q;

endmodule

// ----- rtl/core/rmbv_unit.sv -----
// Brings one 3-D vector to unit length in Q2.30 (block scale, root, three divides).
module rmbv_unit import rmbv_pkg::*; (
  input  logic clk,
  input  logic en,
  input  in_t  vx,
  input  in_t  vy,
  input  in_t  vz,
  output q30_t u [3],
  output logic zero
);

  localparam int A_AT = 3 + SQRT_LAT;
  localparam int SIDE_LEN = A_AT + DIV_LAT;

  typedef struct packed {
    logic [2:0][15:0] a;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  in_t         v [3];
  logic [15:0] mag [3];
  logic [15:0] mx;
  logic [3:0]  up;
  side_t       side_w;

  side_t       side [SIDE_LEN];
  logic [31:0] sq [3];
  logic [31:0] len2;
  logic [31:0] len;
  logic [63:0] num [3];
  logic [31:0] quo [3];

  assign v[0] = vx;
  assign v[1] = vy;
  assign v[2] = vz;

  // Block scaling: shift so the largest magnitude reaches the top octave.
  always_comb begin
    mx = 16'd0;
    up = 4'd0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i][IN_W-1] ? 16'(-v[i]) : 16'(v[i]);
      if (mag[i] > mx) begin
        mx = mag[i];
      end
    end
    for (int b = 0; b < 15; b++) begin
      if (mx[b]) begin
        up = 4'(14 - b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      side_w.a[i] = mag[i] << up;
      side_w.neg[i] = v[i][IN_W-1];
    end
    side_w.zero = (mx == 16'd0);
  end

  // Side data rides along the root and the divide.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_w;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Squares, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= side[0].a[i] * side[0].a[i];
      end
      len2 <= 32'({2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]});
    end
  end

  rmbv_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    ({len2, 32'd0}),
    .root (len)
  );

  // Each component over the length, rounded half away from zero.
  for (genvar i = 0; i < 3; i++) begin : g_div
    assign num[i] = {2'b00, side[A_AT-1].a[i], 46'd0} + {33'd0, len[31:1]};

    rmbv_div u_div (
      .clk (clk),
      .en  (en),
      .num (num[i]),
      .den (len),
      .quo (quo[i])
    );
  end

  // Restore the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= side[SIDE_LEN-1].neg[i] ? -$signed(quo[i]) : $signed(quo[i]);
      end
      zero <= side[SIDE_LEN-1].zero;
    end
  end

endmodule
